// ----- hw/rtl/tsvf_pkg.sv -----
// Shared types and constants for the state-variable bandpass filter core.
package tsvf_pkg;

   // Widths of the datapath
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned STATE_W  = 32;
   localparam int unsigned OPA_W    = 42;   // widest multiplicand: 2*bp
   localparam int unsigned OPB_W    = 18;   // coefficient, zero-extended to signed
   localparam int unsigned HALF_W   = 21;   // multiplicand is split in two halves
   localparam int unsigned PROD_W   = HALF_W + 1 + OPB_W;
   localparam int unsigned ACC_W    = 60;
   localparam int unsigned BP_W     = 41;

   // Configuration port
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   // Register indexes (word address)
   localparam logic [1:0] REG_CUTOFF_GAIN   = 2'd0;
   localparam logic [1:0] REG_DAMPING_TWICE = 2'd1;
   localparam logic [1:0] REG_NORMALIZER    = 2'd2;

   // Register reset values
   localparam logic [15:0] CUTOFF_GAIN_RST   = 16'd0;
   localparam logic [15:0] DAMPING_TWICE_RST = 16'd16384;
   localparam logic [16:0] NORMALIZER_RST    = 17'd65536;

   typedef struct packed {
      logic [15:0] cutoff_gain;
      logic [15:0] damping_twice;
      logic [16:0] normalizer;
   } tsvf_cfg_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic en;      // update the accumulator this cycle
      logic first;   // start from the rounding constant instead of the accumulator
      logic hi;      // use the upper half of the multiplicand
   } tsvf_mac_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_POST
   } tsvf_state_type;

   // Which of the four products is in progress
   typedef enum logic [1:0] {
      STEP_DAMP,
      STEP_GAIN,
      STEP_NORM,
      STEP_FEED
   } tsvf_step_type;

endpackage

// ----- hw/rtl/tsvf_csr.sv -----
// Coefficient registers behind the APB-style configuration port.
module tsvf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tsvf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tsvf_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tsvf_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output tsvf_pkg::tsvf_cfg_type      cfg
);
   import tsvf_pkg::*;

   tsvf_cfg_type cfg_ff;
   tsvf_cfg_type cfg_in;
   logic [1:0]   reg_idx;
   logic         wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CUTOFF_GAIN:   cfg_in.cutoff_gain   = csr_pwdata[15:0];
            REG_DAMPING_TWICE: cfg_in.damping_twice = csr_pwdata[15:0];
            REG_NORMALIZER:    cfg_in.normalizer    = csr_pwdata[16:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_gain   <= CUTOFF_GAIN_RST;
         cfg_ff.damping_twice <= DAMPING_TWICE_RST;
         cfg_ff.normalizer    <= NORMALIZER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_CUTOFF_GAIN:   csr_prdata = CSR_DW'(cfg_ff.cutoff_gain);
         REG_DAMPING_TWICE: csr_prdata = CSR_DW'(cfg_ff.damping_twice);
         REG_NORMALIZER:    csr_prdata = CSR_DW'(cfg_ff.normalizer);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ----- hw/rtl/tsvf_mac.sv -----
// Shared 22x18 signed multiply-accumulate unit, two passes per wide product.
module tsvf_mac (
   input  logic                                clock,
   input  tsvf_pkg::tsvf_mac_ctl_type          ctl,
   input  logic signed [tsvf_pkg::OPA_W-1:0]   opa,
   input  logic signed [tsvf_pkg::OPB_W-1:0]   opb,
   input  logic signed [tsvf_pkg::ACC_W-1:0]   rnd,
   output logic signed [tsvf_pkg::ACC_W-1:0]   acc
);
   import tsvf_pkg::*;

   logic signed [HALF_W:0]   part;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;

   // Low half is unsigned, high half carries the sign
   always_comb begin
      if (ctl.hi) begin
         part = {opa[OPA_W-1], opa[OPA_W-1:HALF_W]};
      end else begin
         part = {1'b0, opa[HALF_W-1:0]};
      end
      prod = part * opb;
      if (ctl.hi) begin
         term = ACC_W'(prod) <<< HALF_W;
      end else begin
         term = ACC_W'(prod);
      end
      base   = ctl.first ? rnd : acc_ff;
      acc_in = base + term;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- hw/rtl/tpt_svf_bandpass_filter_core.sv -----
// Top level of the TPT state-variable bandpass filter: sequencer and state.
//
// Input words arrive on req_ (valid/stall), one signed Q1.15 sample each;
// bandpass words leave on rsp_ (valid/stall), one per input word.
// Coefficients g, 2R and d are written through the csr_ port; the user
// must write them only while the filter is idle, which the block does not
// enforce. pready is always high and reads return the register.
//
// Each sample runs four products through one shared multiply-accumulate
// unit (2R*x, g*(a-s2), (b+s1)*d, g*2bp). Each product takes two passes
// of the 22x18 multiplier (ST_MUL_LO, ST_MUL_HI) and a ST_POST step that
// rescales and loads the next operands. req_stall is high while busy.
// The result is held in an output register; a new sample may be taken
// while it waits. If the previous result is still stalled when the next
// one is ready, the sequencer waits and the integrators are not updated.
// Reset (synchronous) clears both integrators, the output valid and the
// sequencer, and loads the coefficient reset values.
module tpt_svf_bandpass_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tsvf_pkg::SAMPLE_W-1:0] req_sample_in,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsvf_pkg::SAMPLE_W-1:0] rsp_bandpass_out,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsvf_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [tsvf_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [tsvf_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import tsvf_pkg::*;

   localparam logic signed [ACC_W-1:0] RND_13 = ACC_W'(1) <<< 12;
   localparam logic signed [ACC_W-1:0] RND_12 = ACC_W'(1) <<< 11;
   localparam logic signed [ACC_W-1:0] RND_16 = ACC_W'(1) <<< 15;
   localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
   localparam logic signed [48:0] S32_MIN = -49'sd2147483648;
   localparam logic signed [41:0] S16_MAX = 42'sd32767;
   localparam logic signed [41:0] S16_MIN = -42'sd32768;

   tsvf_cfg_type     cfg;
   tsvf_mac_ctl_type mac_ctl;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] rnd;

   tsvf_state_type state_ff, state_in;
   tsvf_step_type  step_ff, step_in;

   logic signed [OPA_W-1:0]    opa_ff, opa_in;
   logic signed [OPB_W-1:0]    opb_ff, opb_in;
   logic signed [STATE_W-1:0]  s1_ff, s1_in;
   logic signed [STATE_W-1:0]  s2_ff, s2_in;
   logic signed [BP_W-1:0]     bp_ff, bp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic post;
   logic finish;
   logic out_free;

   logic signed [ACC_W-1:0] acc_sh13;
   logic signed [ACC_W-1:0] acc_sh12;
   logic signed [ACC_W-1:0] acc_sh16;
   logic signed [BP_W-1:0]  bp_new;
   logic signed [48:0]      s2_sum;
   logic signed [48:0]      s1_sum;
   logic signed [41:0]      y_rnd;
   logic signed [41:0]      y_sh;

   tsvf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsvf_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .opa   (opa_ff),
      .opb   (opb_ff),
      .rnd   (rnd),
      .acc   (acc)
   );

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL_LO;
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_POST;
         ST_POST: begin
            if (step_ff != STEP_FEED) begin
               state_in = ST_MUL_LO;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      accept      = 1'b0;
      post        = 1'b0;
      finish      = 1'b0;
      mac_ctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_MUL_LO: begin
            mac_ctl.en    = 1'b1;
            mac_ctl.first = 1'b1;
         end
         ST_MUL_HI: begin
            mac_ctl.en = 1'b1;
            mac_ctl.hi = 1'b1;
         end
         ST_POST: begin
            post   = (step_ff != STEP_FEED);
            finish = (step_ff == STEP_FEED) & out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Rounding constant preloaded into the accumulator (round half up)
   always_comb begin
      case (step_ff)
         STEP_DAMP: rnd = RND_13;
         STEP_NORM: rnd = RND_16;
         default:   rnd = RND_12;
      endcase
   end

   // Rescaled products
   assign acc_sh13 = acc >>> 13;
   assign acc_sh12 = acc >>> 12;
   assign acc_sh16 = acc >>> 16;
   assign bp_new   = BP_W'(acc_sh16);

   // Integrator and output updates at the end of a sample
   assign s2_sum = 49'(s2_ff) + 49'(acc_sh12);
   assign s1_sum = 49'(bp_ff) + 49'(bp_ff) - 49'(s1_ff);
   assign y_rnd  = 42'(bp_ff) + 42'sd1;
   assign y_sh   = y_rnd >>> 1;

   // Operand and state registers
   always_comb begin
      step_in      = step_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      bp_in        = bp_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (accept) begin
         step_in = STEP_DAMP;
         opa_in  = OPA_W'(req_sample_in);
         opb_in  = OPB_W'(cfg.damping_twice);
      end

      if (post) begin
         case (step_ff)
            STEP_DAMP: begin
               // a - s2, times g
               step_in = STEP_GAIN;
               opa_in  = OPA_W'(acc_sh13) - OPA_W'(s2_ff);
               opb_in  = OPB_W'(cfg.cutoff_gain);
            end
            STEP_GAIN: begin
               // b + s1, times d
               step_in = STEP_NORM;
               opa_in  = OPA_W'(acc_sh12) + OPA_W'(s1_ff);
               opb_in  = OPB_W'(cfg.normalizer);
            end
            STEP_NORM: begin
               // 2bp, times g
               step_in = STEP_FEED;
               bp_in   = bp_new;
               opa_in  = {bp_new, 1'b0};
               opb_in  = OPB_W'(cfg.cutoff_gain);
            end
            default: step_in = step_ff;
         endcase
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         if (s1_sum > S32_MAX) begin
            s1_in = STATE_W'(S32_MAX);
         end else if (s1_sum < S32_MIN) begin
            s1_in = STATE_W'(S32_MIN);
         end else begin
            s1_in = STATE_W'(s1_sum);
         end
         if (s2_sum > S32_MAX) begin
            s2_in = STATE_W'(S32_MAX);
         end else if (s2_sum < S32_MIN) begin
            s2_in = STATE_W'(S32_MIN);
         end else begin
            s2_in = STATE_W'(s2_sum);
         end
         if (y_sh > S16_MAX) begin
            rsp_data_in = SAMPLE_W'(S16_MAX);
         end else if (y_sh < S16_MIN) begin
            rsp_data_in = SAMPLE_W'(S16_MIN);
         end else begin
            rsp_data_in = SAMPLE_W'(y_sh);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_DAMP;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      bp_ff       <= bp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bandpass_out = rsp_data_ff;

endmodule
